[rtl/core/rsu_pkg.sv]
// Package with shared constants and types for the rank-sum statistic core.
package rsu_pkg;
  localparam int MaxSamples = 1024;
  localparam int SampleBits = 16;
  localparam int AddrBits = $clog2(MaxSamples);
  localparam int CntBits = AddrBits + 1;

  typedef enum logic [2:0] {
    ST_LOAD, ST_SORT_RD, ST_SORT_CMP, ST_RANK, ST_FINISH, ST_OUT
  } state_t;

  typedef struct packed {
    logic [19:0] u_twice;
    logic [29:0] tie_sum;
    logic [10:0] count_first;
    logic [10:0] count_second;
    logic empty_group;
    logic overflow;
  } result_t;
endpackage

[rtl/core/rank_sum_u_statistic_core.sv]
// Top level of the rank-sum (Mann-Whitney U) statistic core.
// Samples are stored at one per cycle into a single-port memory of 1024 entries.
// A transaction with tlast starts the ranking: an insertion sort in place,
// followed by one linear ranking pass that folds in each group of equal
// values; if either group is empty, the result is flagged empty_group instead.
// Both passes share the single memory port. No sample is taken while a data set
// is being ranked or while its result waits on the output.
module rank_sum_u_statistic_core
  import rsu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // sample
  input  logic        in_tuser,   // group
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata   // u_twice, tie_sum, count_first, count_second,
                                  // empty_group, overflow, zero fill
);
  localparam int EntBits = SampleBits + 1;

  state_t state_r, state_nxt;
  logic [CntBits-1:0] n1_r, n1_nxt, n2_r, n2_nxt;
  logic ovf_r, ovf_nxt;
  logic [CntBits-1:0] i_r, i_nxt, k_r, k_nxt;
  logic [EntBits-1:0] key_r, key_nxt, prev_r, prev_nxt;
  logic [1:0] ph_r, ph_nxt;
  logic [CntBits-1:0] run_r, run_nxt, cnt1_r, cnt1_nxt;
  logic [21:0] r1_r, r1_nxt, r2_r, r2_nxt;
  logic [29:0] tie_r, tie_nxt;
  logic [29:0] cube_r, cube_nxt;
  logic [1:0] cph_r, cph_nxt;
  logic [CntBits:0] rank2_r, rank2_nxt;
  result_t res_r, res_nxt;

  logic we;
  logic [AddrBits-1:0] addr;
  logic [EntBits-1:0] wdata, rdata;
  logic [CntBits-1:0] n;

  rsu_ram #(.Depth(MaxSamples), .Width(EntBits)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  assign n = n1_r + n2_r;
  assign in_tready = (state_r == ST_LOAD);
  assign out_tvalid = (state_r == ST_OUT);
  assign out_tdata = {2'b0, res_r.overflow, res_r.empty_group, res_r.count_second,
                      res_r.count_first, res_r.tie_sum, res_r.u_twice};

  function automatic logic lt(input logic [EntBits-1:0] a, input logic [EntBits-1:0] b);
    return $signed(a[SampleBits-1:0]) < $signed(b[SampleBits-1:0]);
  endfunction

  logic [21:0] a_v, b_v, sq1, sq2;

  always_comb begin
    state_nxt = state_r; n1_nxt = n1_r; n2_nxt = n2_r; ovf_nxt = ovf_r;
    i_nxt = i_r; k_nxt = k_r; key_nxt = key_r; prev_nxt = prev_r; ph_nxt = ph_r;
    run_nxt = run_r; cnt1_nxt = cnt1_r;
    r1_nxt = r1_r; r2_nxt = r2_r; tie_nxt = tie_r; cube_nxt = cube_r; cph_nxt = cph_r;
    rank2_nxt = rank2_r; res_nxt = res_r;
    we = 1'b0; addr = i_r[AddrBits-1:0]; wdata = key_r;
    sq1 = 22'(n1_r) * 22'(n1_r + 1'b1);
    sq2 = 22'(n2_r) * 22'(n2_r + 1'b1);
    a_v = r1_r - sq1;
    b_v = r2_r - sq2;
    case (state_r)
      ST_LOAD: begin
        addr = n[AddrBits-1:0];
        wdata = {in_tuser, in_tdata};
        if (in_tvalid) begin
          if (n < CntBits'(MaxSamples)) begin
            we = 1'b1;
            if (in_tuser) n2_nxt = n2_r + 1'b1;
            else n1_nxt = n1_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_tlast) begin
            i_nxt = CntBits'(1); ph_nxt = 2'd0;
            state_nxt = ST_SORT_RD;
          end
        end
      end
      ST_SORT_RD: begin
        // ph 0: read key at i; ph 1: capture key, read k-1.
        if (n1_nxt == '0 || n2_nxt == '0 || i_r >= n) begin
          if (n1_r == '0 || n2_r == '0) begin
            res_nxt = '{20'd0, 30'd0, n1_r, n2_r, 1'b1, ovf_r};
            state_nxt = ST_OUT;
          end else begin
            i_nxt = '0; ph_nxt = 2'd0; r1_nxt = '0; r2_nxt = '0; tie_nxt = '0;
            run_nxt = '0; cnt1_nxt = '0;
            state_nxt = ST_RANK;
          end
        end else if (ph_r == 2'd0) begin
          addr = i_r[AddrBits-1:0];
          ph_nxt = 2'd1;
        end else begin
          key_nxt = rdata;
          k_nxt = i_r;
          addr = AddrBits'(i_r - 1'b1);
          state_nxt = ST_SORT_CMP;
        end
      end
      ST_SORT_CMP: begin
        // rdata holds entry k-1.
        if (lt(key_r, rdata)) begin
          we = 1'b1; addr = k_r[AddrBits-1:0]; wdata = rdata;
          k_nxt = k_r - 1'b1;
          if (k_r == CntBits'(1)) begin
            ph_nxt = 2'd2;
          end else begin
            ph_nxt = 2'd3;
          end
          state_nxt = ST_FINISH;
        end else begin
          we = 1'b1; addr = k_r[AddrBits-1:0]; wdata = key_r;
          i_nxt = i_r + 1'b1; ph_nxt = 2'd0;
          state_nxt = ST_SORT_RD;
        end
      end
      ST_FINISH: begin
        // Sort helper: ph 3 reads k-1 and returns to compare; ph 2 places key at 0.
        if (ph_r == 2'd3) begin
          addr = AddrBits'(k_r - 1'b1);
          state_nxt = ST_SORT_CMP;
        end else begin
          we = 1'b1; addr = '0; wdata = key_r;
          i_nxt = i_r + 1'b1; ph_nxt = 2'd0;
          state_nxt = ST_SORT_RD;
        end
      end
      ST_RANK: begin
        // Run scan: ph 0 issues read of i, ph 1 consumes it. A run closes when
        // the value changes or the data ends; its ranks and cube are folded in
        // over the cycles of cph.
        if (cph_r != 2'd0) begin
          case (cph_r)
            2'd1: begin
              cube_nxt = 30'(run_r) * 30'(run_r);
              rank2_nxt = i_r - run_r + i_r + 1'b1;
              cph_nxt = 2'd2;
            end
            2'd2: begin
              cube_nxt = 30'(cube_r * 30'(run_r)) - 30'(run_r);
              r1_nxt = r1_r + 22'(rank2_r) * 22'(cnt1_r);
              cph_nxt = 2'd3;
            end
            default: begin
              tie_nxt = tie_r + cube_r;
              r2_nxt = r2_r + 22'(rank2_r) * 22'(run_r - cnt1_r);
              run_nxt = '0; cnt1_nxt = '0; cph_nxt = 2'd0;
            end
          endcase
        end else if (i_r >= n) begin
          if (run_r != '0) begin
            cph_nxt = 2'd1;
          end else begin
            res_nxt.u_twice = (a_v < b_v) ? a_v[19:0] : b_v[19:0];
            res_nxt.tie_sum = tie_r;
            res_nxt.count_first = n1_r;
            res_nxt.count_second = n2_r;
            res_nxt.empty_group = 1'b0;
            res_nxt.overflow = ovf_r;
            state_nxt = ST_OUT;
          end
        end else if (ph_r == 2'd0) begin
          addr = i_r[AddrBits-1:0];
          ph_nxt = 2'd1;
        end else if (run_r != '0 && rdata[SampleBits-1:0] != prev_r[SampleBits-1:0]) begin
          cph_nxt = 2'd1;
          ph_nxt = 2'd0;
        end else begin
          prev_nxt = rdata;
          run_nxt = run_r + 1'b1;
          if (!rdata[SampleBits]) cnt1_nxt = cnt1_r + 1'b1;
          i_nxt = i_r + 1'b1;
          ph_nxt = 2'd0;
        end
      end
      ST_OUT: begin
        if (out_tready) begin
          n1_nxt = '0; n2_nxt = '0; ovf_nxt = 1'b0;
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      n1_r <= '0; n2_r <= '0; ovf_r <= 1'b0; cph_r <= 2'd0; ph_r <= 2'd0;
    end else begin
      state_r <= state_nxt;
      n1_r <= n1_nxt; n2_r <= n2_nxt; ovf_r <= ovf_nxt; cph_r <= cph_nxt; ph_r <= ph_nxt;
    end
    i_r <= i_nxt; k_r <= k_nxt; key_r <= key_nxt; prev_r <= prev_nxt;
    run_r <= run_nxt; cnt1_r <= cnt1_nxt;
    r1_r <= r1_nxt; r2_r <= r2_nxt; tie_r <= tie_nxt; cube_r <= cube_nxt;
    rank2_r <= rank2_nxt; res_r <= res_nxt;
  end
endmodule

[rtl/core/rsu_ram.sv]
// Single-port synchronous memory for the sample entries.
module rsu_ram #(
  parameter int Depth = 1024,
  parameter int Width = 17
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
